FILE: rtl/spmp_pkg.sv
// ---------------------------------------------------------------------------
// Skeletal pose matrix palette package
// Shared types, command and status structs, and saturation and index helpers.
// ---------------------------------------------------------------------------
package spmp_pkg;

    localparam int DATA_W  = 32;
    localparam int ACC_W   = 64;
    localparam int NWORDS  = 10;
    localparam int IN_TDW  = 328;
    localparam int OUT_TDW = 136;
    localparam int CNT_W   = 7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_QUAT,
        OP_ROT,
        OP_LOC,
        OP_PRD,
        OP_PCPY,
        OP_GLOB,
        OP_IBCPY,
        OP_SKIN,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_LOAD,
        S_QUAT,
        S_ROT,
        S_LOC,
        S_PRD,
        S_PCPY,
        S_GLOB,
        S_IBCPY,
        S_SKIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [5:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic kf;
        logic load_ok;
        logic bone_ok;
    } t_dp_sts;

    // clamp a wide signed value into 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -ACC_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

    // column/row of a local matrix element to its rotation entry (col*3+row)
    function automatic logic [3:0] rot_sel(input logic [3:0] e);
        return 4'({e[3:2], 1'b0}) + 4'(e[3:2]) + 4'(e[1:0]);
    endfunction

endpackage

FILE: rtl/spmp_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module spmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/spmp_ctrl.sv
// ---------------------------------------------------------------------------
// Skeletal pose controller
// Sequences load writes, the local/global/skin matrix passes and emission.
// ---------------------------------------------------------------------------
module spmp_ctrl
    import spmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   w_len;

    // issue count of the current pass; a final idle slot drains the pipeline
    always_comb begin
        case (r_state)
            S_QUAT:  w_len = CNT_W'(9);
            S_ROT:   w_len = CNT_W'(1);
            S_LOC:   w_len = CNT_W'(16);
            S_PRD:   w_len = CNT_W'(1);
            S_PCPY:  w_len = CNT_W'(16);
            S_GLOB:  w_len = CNT_W'(64);
            S_IBCPY: w_len = CNT_W'(16);
            S_SKIN:  w_len = CNT_W'(64);
            default: w_len = CNT_W'(0);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_cnt = '0;
                if (!i_sts.bone_ok) begin
                    n_state = S_IDLE;
                end else if (i_sts.kf) begin
                    n_state = S_QUAT;
                end else if (i_sts.load_ok) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(3)) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(3)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                if (r_cnt == w_len) begin
                    n_cnt = '0;
                    case (r_state)
                        S_QUAT:  n_state = S_ROT;
                        S_ROT:   n_state = S_LOC;
                        S_LOC:   n_state = S_PRD;
                        S_PRD:   n_state = S_PCPY;
                        S_PCPY:  n_state = S_GLOB;
                        S_GLOB:  n_state = S_IBCPY;
                        S_IBCPY: n_state = S_SKIN;
                        S_SKIN:  n_state = S_EMIT;
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.idx   = r_cnt[5:0];
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                end
            end
            S_LOAD:  o_cmd.op = OP_LOAD;
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.op    = OP_EMIT;
            end
            S_QUAT:  o_cmd.op = (r_cnt == w_len) ? OP_NONE : OP_QUAT;
            S_ROT:   o_cmd.op = (r_cnt == w_len) ? OP_NONE : OP_ROT;
            S_LOC:   o_cmd.op = (r_cnt == w_len) ? OP_NONE : OP_LOC;
            S_PRD:   o_cmd.op = (r_cnt == w_len) ? OP_NONE : OP_PRD;
            S_PCPY:  o_cmd.op = (r_cnt == w_len) ? OP_NONE : OP_PCPY;
            S_GLOB:  o_cmd.op = (r_cnt == w_len) ? OP_NONE : OP_GLOB;
            S_IBCPY: o_cmd.op = (r_cnt == w_len) ? OP_NONE : OP_IBCPY;
            S_SKIN:  o_cmd.op = (r_cnt == w_len) ? OP_NONE : OP_SKIN;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/spmp_dp.sv
// ---------------------------------------------------------------------------
// Skeletal pose datapath
// Shared multiply-accumulate unit, matrix registers and pose/bind stores.
// ---------------------------------------------------------------------------
module spmp_dp
    import spmp_pkg::*;
#(
    parameter int MAX_BONES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic                i_in_kind,
    input  logic [IN_TDW-1:0]   i_in_tdata,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data,
    output t_dp_sts             o_sts,
    output logic [OUT_TDW-1:0]  o_out_tdata,
    output logic                o_out_tlast
);

    localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int AW = BW + 4;
    localparam logic signed [ACC_W-1:0] FX_ONE = ACC_W'(64'sd1) <<< FRAC_BITS;

    logic                      r_kind;
    logic [5:0]                r_bone;
    logic signed [DATA_W-1:0]  r_w [0:NWORDS-1];
    logic signed [ACC_W-1:0]   r_q [0:8];
    logic signed [DATA_W-1:0]  r_rot [0:8];
    logic signed [DATA_W-1:0]  r_loc [0:15];
    logic signed [DATA_W-1:0]  r_par [0:15];
    logic signed [DATA_W-1:0]  r_glob [0:15];
    logic signed [DATA_W-1:0]  r_ib [0:15];
    logic signed [DATA_W-1:0]  r_skin [0:15];
    logic [5:0]                r_parent;
    logic [6:0]                r_num_bones;
    logic signed [ACC_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    t_op                       r_op2;
    logic [5:0]                r_idx2;

    logic signed [DATA_W-1:0]  w_a, w_b;
    logic signed [ACC_W-1:0]   w_psh, w_accn;
    logic [8:0]                w_bone_ext, w_par_ext;
    logic [BW-1:0]             w_bone_idx, w_par_idx;
    logic [3:0]                w_rsel;
    logic                      w_par_ok;
    logic [3:0]                w_e2;

    logic                      w_g_we, w_ib_we, w_p_we;
    logic [AW-1:0]             w_g_waddr, w_g_raddr, w_ib_waddr, w_ib_raddr;
    logic [DATA_W-1:0]         w_g_wdata, w_ib_wdata, w_g_rdata, w_ib_rdata;
    logic [5:0]                w_p_rdata;

    assign w_bone_ext = {3'b000, r_bone};
    assign w_par_ext  = {3'b000, r_parent};
    assign w_bone_idx = w_bone_ext[BW-1:0];
    assign w_par_idx  = w_par_ext[BW-1:0];
    assign w_par_ok   = (32'(r_parent) < MAX_BONES);
    assign w_rsel     = rot_sel(i_cmd.idx[3:0]);
    assign w_e2       = r_idx2[5:2];

    assign o_sts.kf      = r_kind;
    assign o_sts.load_ok = (r_w[4][DATA_W-1:2] == '0);
    assign o_sts.bone_ok = (32'(r_bone) < MAX_BONES);

    // stage one operand select
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.op)
            OP_QUAT: begin
                case (i_cmd.idx[3:0])
                    4'd0:    begin w_a = r_w[7]; w_b = r_w[7]; end
                    4'd1:    begin w_a = r_w[8]; w_b = r_w[8]; end
                    4'd2:    begin w_a = r_w[9]; w_b = r_w[9]; end
                    4'd3:    begin w_a = r_w[7]; w_b = r_w[8]; end
                    4'd4:    begin w_a = r_w[7]; w_b = r_w[9]; end
                    4'd5:    begin w_a = r_w[8]; w_b = r_w[9]; end
                    4'd6:    begin w_a = r_w[6]; w_b = r_w[7]; end
                    4'd7:    begin w_a = r_w[6]; w_b = r_w[8]; end
                    default: begin w_a = r_w[6]; w_b = r_w[9]; end
                endcase
            end
            OP_LOC: begin
                if (i_cmd.idx[3:2] != 2'd3 && i_cmd.idx[1:0] != 2'd3) begin
                    w_a = r_rot[w_rsel];
                end
                case (i_cmd.idx[3:2])
                    2'd0:    w_b = r_w[3];
                    2'd1:    w_b = r_w[4];
                    default: w_b = r_w[5];
                endcase
            end
            OP_GLOB: begin
                w_a = r_par[{i_cmd.idx[1:0], i_cmd.idx[3:2]}];
                w_b = r_loc[{i_cmd.idx[5:4], i_cmd.idx[1:0]}];
            end
            OP_SKIN: begin
                w_a = r_glob[{i_cmd.idx[1:0], i_cmd.idx[3:2]}];
                w_b = r_ib[{i_cmd.idx[5:4], i_cmd.idx[1:0]}];
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_psh  = r_prod >>> FRAC_BITS;
    assign w_accn = ((r_idx2[1:0] == 2'd0) ? '0 : r_acc) + w_psh;

    // memory ports
    always_comb begin
        w_ib_we    = (i_cmd.op == OP_LOAD);
        w_p_we     = (i_cmd.op == OP_LOAD) && (i_cmd.idx[1:0] == 2'd0);
        w_ib_waddr = {w_bone_idx, r_w[4][1:0], i_cmd.idx[1:0]};
        case (i_cmd.idx[1:0])
            2'd0:    w_ib_wdata = r_w[0];
            2'd1:    w_ib_wdata = r_w[1];
            2'd2:    w_ib_wdata = r_w[2];
            default: w_ib_wdata = r_w[3];
        endcase
        w_ib_raddr = {w_bone_idx, i_cmd.idx[3:0]};
        w_g_raddr  = {w_par_idx, i_cmd.idx[3:0]};
        w_g_we     = (r_op2 == OP_GLOB) && (r_idx2[1:0] == 2'd3);
        w_g_waddr  = {w_bone_idx, w_e2};
        w_g_wdata  = sat32(w_accn);
    end

    spmp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BONES * 16)) u_glob_ram (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr (w_g_waddr),
        .i_wdata (w_g_wdata),
        .i_raddr (w_g_raddr),
        .o_rdata (w_g_rdata)
    );

    spmp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BONES * 16)) u_ib_ram (
        .i_clk   (i_clk),
        .i_we    (w_ib_we),
        .i_waddr (w_ib_waddr),
        .i_wdata (w_ib_wdata),
        .i_raddr (w_ib_raddr),
        .o_rdata (w_ib_rdata)
    );

    spmp_ram #(.WIDTH(6), .DEPTH(MAX_BONES)) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_bone_idx),
        .i_wdata (r_w[5][5:0]),
        .i_raddr (w_bone_idx),
        .o_rdata (w_p_rdata)
    );

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bones <= 7'd1;
            r_op2       <= OP_NONE;
        end else begin
            if (i_cfg_we) begin
                r_num_bones <= i_cfg_data;
            end
            r_op2 <= i_cmd.op;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        r_idx2 <= i_cmd.idx;

        if (i_cmd.op == OP_LATCH) begin
            r_kind <= i_in_kind;
            r_bone <= i_in_tdata[5:0];
            for (int i = 0; i < NWORDS; i++) begin
                r_w[i] <= i_in_tdata[6 + DATA_W*i +: DATA_W];
            end
            r_loc[3]  <= '0;
            r_loc[7]  <= '0;
            r_loc[11] <= '0;
            r_loc[12] <= i_in_tdata[6 +: DATA_W];
            r_loc[13] <= i_in_tdata[6 + DATA_W +: DATA_W];
            r_loc[14] <= i_in_tdata[6 + 2*DATA_W +: DATA_W];
            r_loc[15] <= sat32(FX_ONE);
        end

        if (i_cmd.op == OP_ROT) begin
            r_rot[0] <= sat32(FX_ONE - ((r_q[1] + r_q[2]) <<< 1));
            r_rot[1] <= sat32((r_q[3] + r_q[8]) <<< 1);
            r_rot[2] <= sat32((r_q[4] - r_q[7]) <<< 1);
            r_rot[3] <= sat32((r_q[3] - r_q[8]) <<< 1);
            r_rot[4] <= sat32(FX_ONE - ((r_q[0] + r_q[2]) <<< 1));
            r_rot[5] <= sat32((r_q[5] + r_q[6]) <<< 1);
            r_rot[6] <= sat32((r_q[4] + r_q[7]) <<< 1);
            r_rot[7] <= sat32((r_q[5] - r_q[6]) <<< 1);
            r_rot[8] <= sat32(FX_ONE - ((r_q[0] + r_q[1]) <<< 1));
        end

        case (r_op2)
            OP_QUAT: r_q[r_idx2[3:0]] <= w_psh;
            OP_LOC: begin
                if (r_idx2[3:2] != 2'd3 && r_idx2[1:0] != 2'd3) begin
                    r_loc[r_idx2[3:0]] <= sat32(w_psh);
                end
            end
            OP_PRD: r_parent <= w_p_rdata;
            OP_PCPY: begin
                if (r_bone == 6'd0) begin
                    r_par[r_idx2[3:0]] <= (r_idx2[3:2] == r_idx2[1:0]) ?
                                          sat32(FX_ONE) : '0;
                end else begin
                    r_par[r_idx2[3:0]] <= w_par_ok ? w_g_rdata : '0;
                end
            end
            OP_GLOB: begin
                r_acc <= w_accn;
                if (r_idx2[1:0] == 2'd3) begin
                    r_glob[w_e2] <= sat32(w_accn);
                end
            end
            OP_IBCPY: r_ib[r_idx2[3:0]] <= w_ib_rdata;
            OP_SKIN: begin
                r_acc <= w_accn;
                if (r_idx2[1:0] == 2'd3) begin
                    r_skin[w_e2] <= sat32(w_accn);
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // result column: bone, column, rows 0..3
    assign o_out_tdata = {r_skin[{i_cmd.idx[1:0], 2'd3}],
                          r_skin[{i_cmd.idx[1:0], 2'd2}],
                          r_skin[{i_cmd.idx[1:0], 2'd1}],
                          r_skin[{i_cmd.idx[1:0], 2'd0}],
                          i_cmd.idx[1:0], r_bone};
    assign o_out_tlast = (i_cmd.idx[1:0] == 2'd3) &&
                         (({1'b0, r_bone} + 7'd1) == r_num_bones);

endmodule

FILE: rtl/skeletal_pose_matrix_palette.sv
// ---------------------------------------------------------------------------
// Skeletal pose matrix palette
// Builds each bone's skinning matrix from a keyframe and emits four columns.
// ---------------------------------------------------------------------------
// Load items (tuser 0) write one inverse bind column and the parent index of
// a bone and give no result. Keyframe items (tuser 1) build local = T*R*S,
// global = global[parent]*local (bone 0 is the root) and skin =
// global*inverse_bind, then emit skin as four column items, the last column of
// bone num_bones-1 flagged with tlast. One item is processed at a time: a
// keyframe's passes share the one 32x32 multiplier, which serves 9 quaternion
// products, 16 local slots and two 64-step matrix products, and use 16-word
// copies through the single read port of each matrix store; each pass ends
// with an idle slot that drains the multiplier, and emission waits out output
// stalls. Stores are not cleared at reset; load a bone before posing it.
// Values are signed fixed point with FRAC_BITS fraction bits, products floored,
// sums saturated to 32 bits.
module skeletal_pose_matrix_palette
    import spmp_pkg::*;
#(
    parameter int MAX_BONES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // bone[5:0], word0..word9 from bit 6 up, 32 bits each, zero padded
    input  logic [IN_TDW-1:0]   s_axis_tdata,
    // cmd
    input  logic                s_axis_tuser,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // out_bone[5:0], out_column[7:6], elem0..elem3 from bit 8 up
    output logic [OUT_TDW-1:0]  m_axis_tdata,
    // pose_last
    output logic                m_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // num_bones write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [6:0]          i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    spmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    spmp_dp #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_kind   (s_axis_tuser),
        .i_in_tdata  (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (w_sts),
        .o_out_tdata (m_axis_tdata),
        .o_out_tlast (m_axis_tlast)
    );

endmodule
